### rtl/scx_pkg.sv
// ============================================================================
// scx_pkg - shared types and constants of the stick crossing cover tracker
// Command codes, controller states, fixed field widths and the tag that
// travels alongside each entry through the crossing test pipeline.
// ============================================================================
package scx_pkg;

  // Fixed widths of the transaction fields.
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 10;
  localparam int COUNT_W = 11;
  localparam int NEWLY_W = 10;

  // Command codes of an input transaction. The fourth code has no meaning
  // and leaves the store untouched.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH,
    ST_RESULT
  } state_t;

  // Side information that accompanies one stored entry through the crossing
  // test pipeline.
  typedef struct packed {
    logic vld;
    logic covered;
  } cross_tag_t;

endpackage

### rtl/scx_if.sv
// ============================================================================
// scx_if - channel interfaces of the stick crossing cover tracker
// One interface for the command channel and one for the result channel,
// each with valid/ready handshaking and source and sink modports.
// ============================================================================
interface scx_in_if
  import scx_pkg::*;
#(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             command;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [IDX_W-1:0]             query_index;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, query_index,
    input  ready
  );
  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, query_index,
    output ready
  );
endinterface

interface scx_out_if
  import scx_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   stick_index;
  logic               is_top;
  logic               index_valid;
  logic [NEWLY_W-1:0] newly_covered;
  logic [COUNT_W-1:0] segment_count;
  logic               store_full;

  modport source (
    output valid, stick_index, is_top, index_valid, newly_covered,
           segment_count, store_full,
    input  ready
  );
  modport sink (
    input  valid, stick_index, is_top, index_valid, newly_covered,
           segment_count, store_full,
    output ready
  );
endinterface

### rtl/scx_ram.sv
// ============================================================================
// scx_ram - generic simple dual-port RAM
// One write port and one read port; the read data is registered, so it
// appears in the cycle after the read address.
// ============================================================================
module scx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/scx_cross.sv
// ============================================================================
// scx_cross - pipelined proper-crossing test of two segments
// Three register stages: endpoint differences, products, cross products.
// The sign decision is taken from the last stage. One pair enters per cycle.
// ============================================================================
module scx_cross
  import scx_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cross_tag_t                   tag_in,
  input  logic signed [COORD_BITS-1:0] px0,
  input  logic signed [COORD_BITS-1:0] py0,
  input  logic signed [COORD_BITS-1:0] px1,
  input  logic signed [COORD_BITS-1:0] py1,
  input  logic signed [COORD_BITS-1:0] qx0,
  input  logic signed [COORD_BITS-1:0] qy0,
  input  logic signed [COORD_BITS-1:0] qx1,
  input  logic signed [COORD_BITS-1:0] qy1,
  output cross_tag_t                   tag_out,
  output logic                         hit
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;
  localparam int NP = 10;
  localparam int NC = 5;

  logic signed [DW-1:0] dpx, dpy, dqx, dqy, ax, ay, bx, by, cx, cy, ex, ey;
  logic signed [DW-1:0] da_nxt [NP];
  logic signed [DW-1:0] db_nxt [NP];
  logic signed [DW-1:0] da_r [NP];
  logic signed [DW-1:0] db_r [NP];
  logic signed [PW-1:0] pr_r [NP];
  logic signed [SW-1:0] cr_r [NC];
  logic [NC-1:0]        pos, neg;
  cross_tag_t           tag1_r, tag2_r, tag3_r;

  always_comb begin
    dpx = DW'(px1) - DW'(px0);
    dpy = DW'(py1) - DW'(py0);
    dqx = DW'(qx1) - DW'(qx0);
    dqy = DW'(qy1) - DW'(qy0);
    ax  = DW'(qx0) - DW'(px0);
    ay  = DW'(qy0) - DW'(py0);
    bx  = DW'(qx1) - DW'(px0);
    by  = DW'(qy1) - DW'(py0);
    cx  = DW'(px0) - DW'(qx0);
    cy  = DW'(py0) - DW'(qy0);
    ex  = DW'(px1) - DW'(qx0);
    ey  = DW'(py1) - DW'(qy0);
    // Pairs 0/1: direction cross product (parallel test).
    da_nxt[0] = dpx; db_nxt[0] = dqy;
    da_nxt[1] = dpy; db_nxt[1] = dqx;
    // Pairs 2..5: new segment's endpoints against the stored segment's line.
    da_nxt[2] = dpx; db_nxt[2] = ay;
    da_nxt[3] = dpy; db_nxt[3] = ax;
    da_nxt[4] = dpx; db_nxt[4] = by;
    da_nxt[5] = dpy; db_nxt[5] = bx;
    // Pairs 6..9: stored segment's endpoints against the new segment's line.
    da_nxt[6] = dqx; db_nxt[6] = cy;
    da_nxt[7] = dqy; db_nxt[7] = cx;
    da_nxt[8] = dqx; db_nxt[8] = ey;
    da_nxt[9] = dqy; db_nxt[9] = ex;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NP; i++) begin
      da_r[i] <= da_nxt[i];
      db_r[i] <= db_nxt[i];
      pr_r[i] <= PW'(da_r[i]) * PW'(db_r[i]);
    end
    for (int k = 0; k < NC; k++) begin
      cr_r[k] <= SW'(pr_r[2*k]) - SW'(pr_r[2*k+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
    end
  end

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      neg[k] = cr_r[k][SW-1];
      pos[k] = !cr_r[k][SW-1] && (cr_r[k] != '0);
    end
    hit = (pos[0] || neg[0])
          && ((pos[1] && neg[2]) || (neg[1] && pos[2]))
          && ((pos[3] && neg[4]) || (neg[3] && pos[4]));
  end

  assign tag_out = tag3_r;

endmodule

### rtl/stick_crossing_cover_tracker_top.sv
// ============================================================================
// stick_crossing_cover_tracker_top - segment store with crossing cover flags
// Stores segments in arrival order, marks stored segments that a new one
// properly crosses, and answers whether a stored segment is still on top.
// ============================================================================
//
//  Channel   Direction  Carries
//  --------  ---------  ------------------------------------------------------
//  in_chan   sink       command, start_x/y, end_x/y, query_index
//  out_chan  source     stick_index, is_top, index_valid, newly_covered,
//                       segment_count, store_full
//
//  Flow: clear, a rejected add and the unused code go from acceptance to the
//  result state, a query by way of the query state. An add to a non-empty
//  store sweeps the segment memory and the cover flag memory one entry per
//  cycle through the 3-stage crossing pipeline, whose flag writes must all
//  land before the new entry is written; an add to an empty store skips it.
//  Reset: rst_n is synchronous and active low; it empties the store at once.
//  Memory contents need no clearing since entries are written before read.
//  Stalls: one transaction is processed at a time; in_chan.ready is high only
//  when idle. A finished result waits in the output register while the next
//  transaction is accepted and processed.
//
module stick_crossing_cover_tracker_top
  import scx_pkg::*;
#(
  parameter int MAX_SEGMENTS = 1024,
  parameter int COORD_BITS   = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  scx_in_if.sink    in_chan,
  scx_out_if.source out_chan
);

  // Address width of the memories and width of the stored-segment count,
  // which must also hold the full depth.
  localparam int AW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_W = 4 * COORD_BITS;
  localparam int XW = CW + IDX_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      n_r, n_nxt;          // entries to sweep for this add
  logic [CW-1:0]      idx_r, idx_nxt;      // next entry to read
  logic [CW-1:0]      wr_idx_r, wr_idx_nxt; // next entry whose test result lands
  logic [NEWLY_W-1:0] newly_r, newly_nxt;
  logic               rd_vld_r, rd_vld_nxt;

  logic signed [COORD_BITS-1:0] qx0_r, qy0_r, qx1_r, qy1_r;

  logic [IDX_W-1:0] res_stick_r, res_stick_nxt;
  logic             res_valid_r, res_valid_nxt;
  logic             res_top_r, res_top_nxt;
  logic             res_full_r, res_full_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_stick_r;
  logic               out_top_r;
  logic               out_idx_valid_r;
  logic [NEWLY_W-1:0] out_newly_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_full_r;

  // --------------------------------------------------------------------------
  // Memory and pipeline wiring
  // --------------------------------------------------------------------------
  logic             in_ready;
  logic             accept;
  logic             load_out;
  logic             latch_seg;
  cmd_t             cmd;

  logic             seg_we;
  logic             seg_re;
  logic [SEG_W-1:0] seg_rdata;

  logic             flag_we;
  logic [AW-1:0]    flag_waddr;
  logic             flag_wdata;
  logic             flag_re;
  logic [AW-1:0]    flag_raddr;
  logic             flag_rdata;
  logic             finish;

  cross_tag_t       tag_in, tag_out;
  logic             hit;
  logic             hit_we;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_chan.valid && in_ready;
  assign cmd      = cmd_t'(in_chan.command);
  assign finish   = (state_r == ST_FINISH);

  // A stored entry that is not yet covered and is crossed becomes covered.
  // Each entry is read once and flagged at most once per add; the sweep never
  // revisits an address, so reads and writes never meet on one entry. The
  // drain state keeps the next transaction away until all writes have landed.
  assign hit_we     = tag_out.vld && !tag_out.covered && hit;
  assign flag_we    = hit_we || finish;
  assign flag_waddr = finish ? n_r[AW-1:0] : wr_idx_r[AW-1:0];
  assign flag_wdata = !finish;

  assign seg_we = finish;
  assign seg_re = (state_r == ST_SWEEP);

  assign flag_re    = seg_re || (accept && (cmd == CMD_QUERY));
  assign flag_raddr = seg_re ? idx_r[AW-1:0] : AW'(in_chan.query_index);

  scx_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (seg_we),
    .waddr (n_r[AW-1:0]),
    .wdata ({qx0_r, qy0_r, qx1_r, qy1_r}),
    .re    (seg_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (seg_rdata)
  );

  scx_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SEGMENTS)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (flag_re),
    .raddr (flag_raddr),
    .rdata (flag_rdata)
  );

  assign tag_in.vld     = rd_vld_r;
  assign tag_in.covered = flag_rdata;

  // The stored segment plays the role of p and the new one of q.
  scx_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (tag_in),
    .px0     (seg_rdata[4*COORD_BITS-1:3*COORD_BITS]),
    .py0     (seg_rdata[3*COORD_BITS-1:2*COORD_BITS]),
    .px1     (seg_rdata[2*COORD_BITS-1:COORD_BITS]),
    .py1     (seg_rdata[COORD_BITS-1:0]),
    .qx0     (qx0_r),
    .qy0     (qy0_r),
    .qx1     (qx1_r),
    .qy1     (qy1_r),
    .tag_out (tag_out),
    .hit     (hit)
  );

  // --------------------------------------------------------------------------
  // Controller: next state and datapath updates
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    wr_idx_nxt    = wr_idx_r;
    newly_nxt     = newly_r;
    rd_vld_nxt    = seg_re;
    res_stick_nxt = res_stick_r;
    res_valid_nxt = res_valid_r;
    res_top_nxt   = res_top_r;
    res_full_nxt  = res_full_r;
    latch_seg     = 1'b0;
    load_out      = 1'b0;

    // Test results land in order, one per swept entry.
    if (tag_out.vld) begin
      wr_idx_nxt = wr_idx_r + 1'b1;
      if (hit_we) begin
        newly_nxt = newly_r + 1'b1;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_stick_nxt = '0;
          res_valid_nxt = 1'b0;
          res_top_nxt   = 1'b0;
          res_full_nxt  = 1'b0;
          newly_nxt     = '0;
          unique case (cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_RESULT;
            end
            CMD_ADD: begin
              if (count_r >= CW'(MAX_SEGMENTS)) begin
                res_full_nxt = 1'b1;
                state_nxt    = ST_RESULT;
              end else begin
                latch_seg  = 1'b1;
                n_nxt      = count_r;
                idx_nxt    = '0;
                wr_idx_nxt = '0;
                state_nxt  = (count_r == '0) ? ST_FINISH : ST_SWEEP;
              end
            end
            CMD_QUERY: begin
              res_stick_nxt = in_chan.query_index;
              res_valid_nxt = XW'(in_chan.query_index) < XW'(count_r);
              state_nxt     = ST_QUERY;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end
      ST_QUERY: begin
        // The flag of an index beyond the store may be stale; it is masked.
        res_top_nxt = res_valid_r && !flag_rdata;
        state_nxt   = ST_RESULT;
      end
      ST_SWEEP: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt == n_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (wr_idx_r == n_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        count_nxt     = n_r + 1'b1;
        res_stick_nxt = IDX_W'(n_r);
        state_nxt     = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = load_out || (out_valid_r && !out_chan.ready);
  end

  // --------------------------------------------------------------------------
  // Clocked logic
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
      wr_idx_r    <= '0;
    end else begin
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newly_r     <= newly_nxt;
    res_stick_r <= res_stick_nxt;
    res_valid_r <= res_valid_nxt;
    res_top_r   <= res_top_nxt;
    res_full_r  <= res_full_nxt;
    if (latch_seg) begin
      qx0_r <= in_chan.start_x;
      qy0_r <= in_chan.start_y;
      qx1_r <= in_chan.end_x;
      qy1_r <= in_chan.end_y;
    end
    if (load_out) begin
      out_stick_r     <= res_stick_r;
      out_top_r       <= res_top_r;
      out_idx_valid_r <= res_valid_r;
      out_newly_r     <= newly_r;
      out_count_r     <= COUNT_W'(count_r);
      out_full_r      <= res_full_r;
    end
  end

  assign in_chan.ready          = in_ready;
  assign out_chan.valid         = out_valid_r;
  assign out_chan.stick_index   = out_stick_r;
  assign out_chan.is_top        = out_top_r;
  assign out_chan.index_valid   = out_idx_valid_r;
  assign out_chan.newly_covered = out_newly_r;
  assign out_chan.segment_count = out_count_r;
  assign out_chan.store_full    = out_full_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A cover write always targets an entry that belongs to the current sweep.
  a_cover_write_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    hit_we |-> (wr_idx_r < n_r))
    else $error("cover flag written outside the swept range");

  // Results never run ahead of the reads that produce them.
  a_results_behind_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP || state_r == ST_DRAIN) |-> (wr_idx_r <= idx_r))
    else $error("crossing result without a matching read");

  // The new entry is written only once every cover write has landed.
  a_finish_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> (wr_idx_r == n_r) && !rd_vld_r && !tag_out.vld)
    else $error("new entry written while the sweep is still in flight");

  // A rejected add is only reported when the store really is full.
  a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && res_full_r) |-> (count_r == CW'(MAX_SEGMENTS)))
    else $error("store full reported below capacity");

endmodule

### verif/stick_crossing_cover_tracker_top_tb.sv
// ============================================================================
// stick_crossing_cover_tracker_top_tb - self-checking bench for the tracker
// Drives clear, add, query and unused-code transactions into the tracker,
// predicts every result from its own model of the segment store and the
// cover flags, and compares each result field by field. Both channels idle
// at random, and the sender now and then holds back until every earlier
// result has come.
// ============================================================================
module stick_crossing_cover_tracker_top_tb
  import scx_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SEGMENTS = 1024;
  localparam int COORD_BITS   = 16;

  // Least number of useful random transactions after the directed opening.
  localparam int RANDOM_ITEMS = 530;

  // The store never grows much above 250 entries, so even the slowest
  // correct run ends well before the watchdog limit.
  localparam int CYCLE_LIMIT = 1_000_000;

  // The fourth command code has no name in the package.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One input transaction. drain_first makes the sender hold this item back
  // until every earlier result has been collected.
  typedef struct packed {
    bit                           drain_first;
    logic [CMD_W-1:0]             command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [IDX_W-1:0]             query_index;
  } stick_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic [IDX_W-1:0]   stick_index;
    logic               is_top;
    logic               index_valid;
    logic [NEWLY_W-1:0] newly_covered;
    logic [COUNT_W-1:0] segment_count;
    logic               store_full;
  } tracker_report_t;

  // A stored stick, widened so that every cross product is exact.
  typedef struct {
    longint x0;
    longint y0;
    longint x1;
    longint y1;
  } stick_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  scx_in_if #(.COORD_BITS(COORD_BITS)) in_if ();
  scx_out_if                           out_if ();

  stick_crossing_cover_tracker_top #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .COORD_BITS  (COORD_BITS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if.sink),
    .out_chan(out_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench-side drive registers. They start at known values so that the
  // tracker never sees an undefined input, even before reset.
  // --------------------------------------------------------------------------
  logic       drv_valid = 1'b0;
  stick_cmd_t drv_item  = '0;
  logic       mon_ready = 1'b0;

  assign in_if.valid       = drv_valid;
  assign in_if.command     = drv_item.command;
  assign in_if.start_x     = drv_item.start_x;
  assign in_if.start_y     = drv_item.start_y;
  assign in_if.end_x       = drv_item.end_x;
  assign in_if.end_y       = drv_item.end_y;
  assign in_if.query_index = drv_item.query_index;
  assign out_if.ready      = mon_ready;

  // Transactions waiting to be sent, and results waiting to be seen.
  stick_cmd_t      command_backlog[$];
  tracker_report_t tracker_reports_due[$];

  // Both counters change only through nonblocking assignments, so every
  // process that reads them at a clock edge sees the same value.
  int n_sent = 0;
  int n_recv = 0;

  int fail_count    = 0;
  int total_reports = 0;
  int cycle_count   = 0;

  // --------------------------------------------------------------------------
  // Predictor: the bench's own copy of the segment store, the cover flags
  // and the stored count, advanced once for every accepted transaction.
  // --------------------------------------------------------------------------
  stick_t      stick_mem[MAX_SEGMENTS];
  bit          covered_mem[MAX_SEGMENTS];
  int unsigned stick_count = 0;

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Cross product of (b - a) and (c - a); its sign says on which side of the
  // line through a and b the point c lies.
  function automatic longint turn(longint ax, longint ay, longint bx, longint by,
                                  longint cx, longint cy);
    return (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
  endfunction

  // A proper crossing: the sticks are not parallel, and each one has its two
  // endpoints strictly on opposite sides of the other. Touching, collinear
  // overlap and degenerate sticks therefore never count.
  function automatic bit sticks_cross(stick_t p, stick_t q);
    longint dpx, dpy, dqx, dqy;
    int     s1, s2, s3, s4;
    dpx = p.x1 - p.x0;
    dpy = p.y1 - p.y0;
    dqx = q.x1 - q.x0;
    dqy = q.y1 - q.y0;
    if (dpx * dqy - dpy * dqx == 0) return 1'b0;
    s1 = sign_of(turn(p.x0, p.y0, p.x1, p.y1, q.x0, q.y0));
    s2 = sign_of(turn(p.x0, p.y0, p.x1, p.y1, q.x1, q.y1));
    s3 = sign_of(turn(q.x0, q.y0, q.x1, q.y1, p.x0, p.y0));
    s4 = sign_of(turn(q.x0, q.y0, q.x1, q.y1, p.x1, p.y1));
    return (s1 * s2 < 0) && (s3 * s4 < 0);
  endfunction

  function automatic void predict_tracker_report(stick_cmd_t item);
    tracker_report_t rep;
    stick_t          fresh;
    int unsigned     n;
    int unsigned     newly;
    rep   = '0;
    newly = 0;
    case (item.command)
      CMD_CLEAR: begin
        stick_count = 0;
      end
      CMD_ADD: begin
        if (stick_count >= MAX_SEGMENTS) begin
          // A full store rejects the stick and reports only the flag and count.
          rep.store_full = 1'b1;
        end else begin
          fresh.x0 = item.start_x;
          fresh.y0 = item.start_y;
          fresh.x1 = item.end_x;
          fresh.y1 = item.end_y;
          n = stick_count;
          // Sticks already covered are not counted a second time.
          for (int i = 0; i < n; i++) begin
            if (!covered_mem[i] && sticks_cross(stick_mem[i], fresh)) begin
              covered_mem[i] = 1'b1;
              newly++;
            end
          end
          stick_mem[n]      = fresh;
          covered_mem[n]    = 1'b0;
          stick_count       = n + 1;
          rep.stick_index   = IDX_W'(n);
          rep.newly_covered = NEWLY_W'(newly);
        end
      end
      CMD_QUERY: begin
        rep.stick_index = item.query_index;
        if (item.query_index < stick_count) begin
          rep.index_valid = 1'b1;
          rep.is_top      = !covered_mem[item.query_index];
        end
      end
      default: begin
        // The unused code changes nothing and only reports the count.
      end
    endcase
    rep.segment_count = COUNT_W'(stick_count);
    tracker_reports_due = {tracker_reports_due, rep};
  endfunction

  // --------------------------------------------------------------------------
  // Driver. At each edge it first retires a transaction that the tracker has
  // just taken, then either keeps the current one on the bus, waits out its
  // idle gap, or loads the next one. valid gets one assignment per edge, so
  // back-to-back transactions keep it high throughout.
  // --------------------------------------------------------------------------
  int send_wait  = 0;
  bit send_burst = 1'b0;

  always @(posedge clk) begin : drive_proc
    logic holding;
    int   in_flight;
    if (!rst_n) begin
      drv_valid <= 1'b0;
      send_wait  = 0;
    end else begin
      holding   = drv_valid;
      in_flight = n_sent - n_recv;
      if (drv_valid && in_if.ready) begin
        predict_tracker_report(drv_item);
        n_sent   <= n_sent + 1;
        holding   = 1'b0;
        in_flight = in_flight + 1;
      end
      if (!holding) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (command_backlog.size() != 0 &&
                     !(command_backlog[0].drain_first && in_flight != 0)) begin
          drv_item <= command_backlog.pop_front();
          holding   = 1'b1;
          // Now and then switch between gappy traffic and a gap-free run.
          if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
          send_wait = send_burst ? 0 : $urandom_range(0, 10);
        end
      end
      drv_valid <= holding;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each result transaction is checked against the oldest
  // prediction, after which ready may be withdrawn for a freshly drawn
  // random wait.
  // --------------------------------------------------------------------------
  int recv_wait  = 0;
  bit recv_burst = 1'b0;

  always @(posedge clk) begin : monitor_proc
    tracker_report_t got;
    tracker_report_t want;
    logic            rdy;
    if (!rst_n) begin
      mon_ready <= 1'b0;
      recv_wait  = 0;
    end else begin
      rdy = mon_ready;
      if (out_if.valid && mon_ready) begin
        got.stick_index   = out_if.stick_index;
        got.is_top        = out_if.is_top;
        got.index_valid   = out_if.index_valid;
        got.newly_covered = out_if.newly_covered;
        got.segment_count = out_if.segment_count;
        got.store_full    = out_if.store_full;
        n_recv <= n_recv + 1;
        if (tracker_reports_due.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result at cycle %0d: idx=%0d count=%0d",
                     cycle_count, got.stick_index, got.segment_count);
          fail_count++;
        end else begin
          want = tracker_reports_due.pop_front();
          if (got.stick_index   !== want.stick_index   ||
              got.is_top        !== want.is_top        ||
              got.index_valid   !== want.index_valid   ||
              got.newly_covered !== want.newly_covered ||
              got.segment_count !== want.segment_count ||
              got.store_full    !== want.store_full) begin
            if (fail_count < 10) begin
              $display("mismatch at cycle %0d", cycle_count);
              $display("  expected idx=%0d top=%0b valid=%0b newly=%0d count=%0d full=%0b",
                       want.stick_index, want.is_top, want.index_valid,
                       want.newly_covered, want.segment_count, want.store_full);
              $display("  actual   idx=%0d top=%0b valid=%0b newly=%0d count=%0d full=%0b",
                       got.stick_index, got.is_top, got.index_valid,
                       got.newly_covered, got.segment_count, got.store_full);
            end
            fail_count++;
          end
        end
        if ($urandom_range(0, 29) == 0) recv_burst = !recv_burst;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 10);
        rdy       = (recv_wait == 0);
      end else if (!rdy) begin
        if (recv_wait > 0) recv_wait--;
        rdy = (recv_wait == 0);
      end
      mon_ready <= rdy;
    end
  end

  // Watchdog: a lost result or a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("stick_crossing_cover_tracker_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus generation. gen_count mirrors the stored count only so that
  // queries can be aimed mostly inside the store; prediction does not use it.
  // --------------------------------------------------------------------------
  int unsigned                  gen_count    = 0;
  int unsigned                  useful_items = 0;
  bit                           hold_next    = 1'b0;
  logic signed [COORD_BITS-1:0] last_ex      = '0;
  logic signed [COORD_BITS-1:0] last_ey      = '0;

  // Mostly small coordinates so that crossings, touches and collinear cases
  // are common, with medium, full-range and extreme values mixed in.
  function automatic logic signed [COORD_BITS-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = int'($urandom_range(0, 128)) - 64;
      6, 7:             v = int'($urandom_range(0, 4000)) - 2000;
      8:                v = int'($urandom_range(0, 65535)) - 32768;
      default: begin
        case ($urandom_range(0, 3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return COORD_BITS'(v);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (gen_count != 0 && roll < 7) return IDX_W'($urandom_range(0, gen_count - 1));
    if (roll < 9) return IDX_W'(gen_count + $urandom_range(0, 3));
    return IDX_W'($urandom_range(0, 1023));
  endfunction

  task automatic queue_item(input logic [CMD_W-1:0] cmd,
                            input logic signed [COORD_BITS-1:0] sx, sy, ex, ey,
                            input logic [IDX_W-1:0] qi);
    stick_cmd_t item;
    item.drain_first = hold_next;
    item.command     = cmd;
    item.start_x     = sx;
    item.start_y     = sy;
    item.end_x       = ex;
    item.end_y       = ey;
    item.query_index = qi;
    hold_next        = 1'b0;
    command_backlog  = {command_backlog, item};
    if (cmd != CMD_UNUSED) useful_items++;
    if (cmd == CMD_CLEAR) gen_count = 0;
    if (cmd == CMD_ADD && gen_count < MAX_SEGMENTS) gen_count++;
  endtask

  task automatic add_stick(input int sx, sy, ex, ey);
    queue_item(CMD_ADD, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex),
               COORD_BITS'(ey), IDX_W'($urandom()));
    last_ex = COORD_BITS'(ex);
    last_ey = COORD_BITS'(ey);
  endtask

  // Unused fields of clear, query and the unused code carry random bits.
  task automatic send_other(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] qi);
    queue_item(cmd, rand_coord(), rand_coord(), rand_coord(), rand_coord(), qi);
  endtask

  task automatic add_random_stick();
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
    int unsigned                  roll;
    roll = $urandom_range(0, 11);
    sx   = rand_coord();
    sy   = rand_coord();
    ex   = rand_coord();
    ey   = rand_coord();
    if (roll == 0) begin
      // Degenerate: a single point.
      ex = sx;
      ey = sy;
    end else if (roll == 1) begin
      // Starts where the previous stick ended, so the two only touch.
      sx = last_ex;
      sy = last_ey;
    end
    add_stick(sx, sy, ex, ey);
  endtask

  initial begin : stimulus_proc
    int unsigned steps;
    int unsigned roll;
    int unsigned random_goal;

    // ---- Directed opening ------------------------------------------------
    send_other(CMD_QUERY, '0);              // query of an empty store
    add_stick(-100, 0, 100, 0);             // stick 0, horizontal
    add_stick(0, -100, 0, 100);             // stick 1 crosses stick 0
    send_other(CMD_QUERY, 10'd0);           // now covered
    send_other(CMD_QUERY, 10'd1);           // still on top
    add_stick(0, 50, 50, 50);               // endpoint touches stick 1 only
    add_stick(-50, 0, 200, 0);              // collinear with stick 0, crosses 1
    add_stick(10, 10, 10, 10);              // degenerate point
    add_stick(10, -50, 10, 100);            // crosses 2 and 3, passes the point
    send_other(CMD_QUERY, 10'd4);           // the point is never covered
    add_stick(-32768, -32768, 32767, 32767);
    add_stick(-32768, 32767, 32767, -32768);
    add_stick(32767, -32768, -32768, 32767); // overlaps the previous one exactly
    send_other(CMD_QUERY, 10'd7);
    send_other(CMD_QUERY, 10'd9);
    send_other(CMD_QUERY, 10'd1023);        // far out of range
    send_other(CMD_QUERY, 10'd10);          // also past the count
    send_other(CMD_UNUSED, 10'd1023);
    // The sender lets every outstanding result come back before the clear.
    hold_next = 1'b1;
    send_other(CMD_CLEAR, 10'd1023);
    send_other(CMD_QUERY, 10'd0);           // empty again after clear
    add_stick(-1, -1, 0, 0);
    add_stick(-1, 0, 0, -1);                // tiny crossing next to the origin

    // ---- Random bursts ---------------------------------------------------
    // Each burst usually starts from a cleared store and then mixes adds and
    // queries. Mid-burst clears, the unused code and stray queries form the
    // noise. The store is kept small here to keep each add short.
    random_goal = useful_items + RANDOM_ITEMS;
    while (useful_items < random_goal) begin
      if ($urandom_range(0, 3) == 0) hold_next = 1'b1;
      if ($urandom_range(0, 4) != 0 || gen_count > 150)
        send_other(CMD_CLEAR, IDX_W'($urandom()));
      steps = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(2, 30);
      for (int s = 0; s < steps; s++) begin
        roll = $urandom_range(0, 19);
        if (roll < 12)       add_random_stick();
        else if (roll < 18)  send_other(CMD_QUERY, pick_index());
        else if (roll == 18) send_other(CMD_UNUSED, IDX_W'($urandom()));
        else                 send_other(CMD_CLEAR, IDX_W'($urandom()));
      end
    end

    total_reports = command_backlog.size();

    // ---- Reset, then wait for the traffic to drain -----------------------
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Every transaction yields exactly one result.
    while (n_recv != total_reports) @(posedge clk);
    // An extra wait afterwards catches any stray extra result.
    repeat (20) @(posedge clk);

    if (tracker_reports_due.size() != 0) begin
      $display("%0d predicted results never arrived", tracker_reports_due.size());
      fail_count += tracker_reports_due.size();
    end

    if (fail_count == 0) begin
      $display("stick_crossing_cover_tracker_top test passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("stick_crossing_cover_tracker_top test failed");
    end
    $finish;
  end

endmodule
